FILE: sv/gdc_pkg.sv
// ============================================================================
// gdc_pkg: shared types and constants for the gesture direction classifier
// Holds widths, motion codes, proximity codes and the sequencer state type.
// ============================================================================
package gdc_pkg;

    localparam int BufDepth  = 32;
    localparam int AccWidth  = 16;
    localparam int CntWidth  = $clog2(BufDepth + 1);
    localparam int IdxWidth  = $clog2(BufDepth);

    localparam int MinBatch   = 4;
    localparam int NearNeeded = 10;
    localparam int FarNeeded  = 2;

    typedef enum logic [2:0] {
        MOT_NONE  = 3'd0,
        MOT_LEFT  = 3'd1,
        MOT_RIGHT = 3'd2,
        MOT_UP    = 3'd3,
        MOT_DOWN  = 3'd4,
        MOT_NEAR  = 3'd5,
        MOT_FAR   = 3'd6
    } t_motion;

    typedef enum logic [1:0] {
        PROX_NONE = 2'd0,
        PROX_NEAR = 2'd1,
        PROX_FAR  = 2'd2
    } t_prox;

    typedef enum logic [1:0] {
        CFG_PRESENCE = 2'd0,
        CFG_SWIPE    = 2'd1,
        CFG_STILL    = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_FWD,
        ST_SCAN_BWD,
        ST_DIV,
        ST_UPDATE,
        ST_RULES,
        ST_OUT
    } t_state;

endpackage

FILE: sv/gesture_direction_classifier.sv
// ============================================================================
// gesture_direction_classifier: swipe and near/far detection from four
// photodiode channels, with a sample memory and a shared serial divider.
// ============================================================================
// Usage: each input item on the s_axis side is either a sample push
// (tuser = 0) or a finish command (tuser = 1). Samples go into a 32-entry
// synchronous memory. An item with tlast set ends a batch and yields one
// result item on the m_axis side; a finish yields one result and clears
// all gesture state. Other pushes produce nothing.
// A batch end of more than 4 samples with no overflow scans the memory
// forward for the first valid sample and backward for the last, one read
// per cycle; if none is valid, the result follows the forward scan.
// Otherwise it computes four ratios on one restoring divider, then runs
// the ST_UPDATE and ST_RULES states before the result is valid.
// One item is handled at a time; s_axis_tready is low while a batch or
// finish is in work or while a result waits. A stalled receiver holds the
// result in the output register. Configuration writes on the cfg channel
// are always taken. Reset restores register defaults and clears the control
// state, not the datapath registers; the sample memory needs no clearing
// pass since only entries written in the current batch are read.
// ============================================================================
module gesture_direction_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: up_level[7:0], down_level[15:8], left_level[23:16], right_level[31:24]
    input  logic [31:0] s_axis_tdata,
    // tuser: command
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: motion[2:0], near_far_event[3], gesture_done[4], batch_overflow[5], zeros
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int AW = gdc_pkg::AccWidth;
    localparam int CW = gdc_pkg::CntWidth;
    localparam int IW = gdc_pkg::IdxWidth;

    // Configuration registers.
    logic [7:0]  r_thr;
    logic [14:0] r_swipe;
    logic [7:0]  r_still;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= 8'd10;
            r_swipe <= 15'd50;
            r_still <= 8'd20;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gdc_pkg::CFG_PRESENCE: r_thr   <= i_cfg_data[7:0];
                gdc_pkg::CFG_SWIPE:    r_swipe <= i_cfg_data;
                gdc_pkg::CFG_STILL:    r_still <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sample memory with registered read.
    logic [31:0] mem [gdc_pkg::BufDepth];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= s_axis_tdata;
        r_rdata <= mem[mem_raddr];
    end

    // State.
    gdc_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic signed [AW-1:0] r_vacc, n_vacc, r_hacc, n_hacc;
    logic signed [1:0] r_vdir, n_vdir, r_hdir, n_hdir;
    logic [7:0] r_near, n_near, r_far, n_far;
    gdc_pkg::t_prox   r_prox, n_prox;
    gdc_pkg::t_motion r_last, n_last;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_rd_pend, n_rd_pend;
    logic [31:0] r_first, n_first, r_lastw, n_lastw;
    logic [1:0]  r_dsel, n_dsel;
    logic signed [7:0] r_ratio [4];
    logic signed [7:0] n_ratio [4];
    logic        r_ovalid, n_ovalid;
    logic [5:0]  r_odata, n_odata;

    // Serial divider: unsigned 15-bit numerator by 9-bit denominator.
    logic [14:0] r_dq, n_dq;
    logic [8:0]  r_drem, n_drem, r_dden, n_dden;
    logic        r_dneg, n_dneg;
    logic [3:0]  r_dstep, n_dstep;
    logic        r_dbusy, n_dbusy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdc_pkg::ST_IDLE;
            r_count <= '0; r_ovf <= 1'b0;
            r_vacc <= '0; r_hacc <= '0; r_vdir <= '0; r_hdir <= '0;
            r_near <= '0; r_far <= '0;
            r_prox <= gdc_pkg::PROX_NONE; r_last <= gdc_pkg::MOT_NONE;
            r_ovalid <= 1'b0; r_rd_pend <= 1'b0; r_dbusy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count; r_ovf <= n_ovf;
            r_vacc <= n_vacc; r_hacc <= n_hacc; r_vdir <= n_vdir; r_hdir <= n_hdir;
            r_near <= n_near; r_far <= n_far; r_prox <= n_prox; r_last <= n_last;
            r_ovalid <= n_ovalid; r_rd_pend <= n_rd_pend; r_dbusy <= n_dbusy;
        end
        r_ptr <= n_ptr; r_first <= n_first; r_lastw <= n_lastw;
        r_dsel <= n_dsel; r_ratio <= n_ratio; r_odata <= n_odata;
        r_dq <= n_dq; r_drem <= n_drem; r_dden <= n_dden;
        r_dneg <= n_dneg; r_dstep <= n_dstep;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_odata};

    // Helpers.
    function automatic logic valid_w(input logic [31:0] w, input logic [7:0] t);
        valid_w = (w[7:0] > t) && (w[15:8] > t) && (w[23:16] > t) && (w[31:24] > t);
    endfunction

    function automatic gdc_pkg::t_motion decode_f(
        input gdc_pkg::t_prox p, input logic signed [1:0] v, input logic signed [1:0] h,
        input logic signed [AW-1:0] va, input logic signed [AW-1:0] ha,
        input gdc_pkg::t_motion cur);
        logic [AW:0] mv, mh;
        mv = va[AW-1] ? -{va[AW-1], va} : {va[AW-1], va};
        mh = ha[AW-1] ? -{ha[AW-1], ha} : {ha[AW-1], ha};
        decode_f = cur;
        if (p == gdc_pkg::PROX_NEAR) decode_f = gdc_pkg::MOT_NEAR;
        else if (p == gdc_pkg::PROX_FAR) decode_f = gdc_pkg::MOT_FAR;
        else if (v == -2'sd1 && h == 2'sd0) decode_f = gdc_pkg::MOT_UP;
        else if (v == 2'sd1 && h == 2'sd0) decode_f = gdc_pkg::MOT_DOWN;
        else if (v == 2'sd0 && h == 2'sd1) decode_f = gdc_pkg::MOT_RIGHT;
        else if (v == 2'sd0 && h == -2'sd1) decode_f = gdc_pkg::MOT_LEFT;
        else if (v != 2'sd0 && h != 2'sd0) begin
            if (mv > mh) decode_f = v[1] ? gdc_pkg::MOT_UP : gdc_pkg::MOT_DOWN;
            else decode_f = h[1] ? gdc_pkg::MOT_LEFT : gdc_pkg::MOT_RIGHT;
        end
    endfunction

    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0] a, input logic signed [8:0] d);
        logic signed [AW:0] s;
        s = {a[AW-1], a} + (AW+1)'(d);
        if (s[AW] != s[AW-1]) sat_add = s[AW] ? {1'b1, {(AW-1){1'b0}}}
                                              : {1'b0, {(AW-1){1'b1}}};
        else sat_add = s[AW-1:0];
    endfunction

    function automatic logic signed [1:0] dir_f(
        input logic signed [AW-1:0] a, input logic [14:0] s);
        logic signed [AW+1:0] ae, se;
        ae = (AW+2)'(a);
        se = (AW+2)'(signed'({1'b0, s}));
        if (ae >= se) dir_f = 2'sd1;
        else if (ae <= -se) dir_f = -2'sd1;
        else dir_f = 2'sd0;
    endfunction

    // Per-batch deltas from the four ratios.
    logic signed [8:0] ud, lr;
    logic [8:0] mud, mlr;
    logic still, both_zero;
    logic signed [AW-1:0] vacc_new, hacc_new;
    always_comb begin
        ud  = 9'(r_ratio[0]) - 9'(r_ratio[2]);
        lr  = 9'(r_ratio[1]) - 9'(r_ratio[3]);
        mud = ud[8] ? -ud : ud;
        mlr = lr[8] ? -lr : lr;
        still = (mud < {1'b0, r_still}) && (mlr < {1'b0, r_still});
        both_zero = (ud == 9'sd0) && (lr == 9'sd0);
        vacc_new = sat_add(r_vacc, ud);
        hacc_new = sat_add(r_hacc, lr);
    end

    // Divider operand selection: ratios of last (0,1) and first (2,3).
    logic [31:0] dw;
    logic [7:0]  da, db;
    assign dw = r_dsel[1] ? r_first : r_lastw;
    assign da = r_dsel[0] ? dw[23:16] : dw[7:0];
    assign db = r_dsel[0] ? dw[31:24] : dw[15:8];

    logic [10:0] dtrial;
    logic [9:0]  dshift;
    logic [7:0]  dqmag;
    logic [7:0]  ddiff;

    logic push, fin, rdv;
    assign push = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
    assign fin  = s_axis_tvalid && s_axis_tready && s_axis_tuser;
    assign rdv  = valid_w(r_rdata, r_thr);

    // Sequencer.
    always_comb begin
        n_state = r_state; n_count = r_count; n_ovf = r_ovf;
        n_vacc = r_vacc; n_hacc = r_hacc; n_vdir = r_vdir; n_hdir = r_hdir;
        n_near = r_near; n_far = r_far; n_prox = r_prox; n_last = r_last;
        n_ptr = r_ptr; n_rd_pend = 1'b0; n_first = r_first; n_lastw = r_lastw;
        n_dsel = r_dsel; n_ratio = r_ratio; n_odata = r_odata;
        n_dq = r_dq; n_drem = r_drem; n_dden = r_dden; n_dneg = r_dneg;
        n_dstep = r_dstep; n_dbusy = r_dbusy;
        n_ovalid = r_ovalid && !m_axis_tready;
        s_axis_tready = 1'b0;
        mem_we = 1'b0;
        mem_waddr = r_count[IW-1:0];
        mem_raddr = r_ptr[IW-1:0];
        dshift = '0; dtrial = '0; dqmag = '0; ddiff = '0;
        unique case (r_state)
            gdc_pkg::ST_IDLE: begin
                s_axis_tready = !r_ovalid;
                if (fin) begin
                    n_odata = {3'b010, decode_f(r_prox, r_vdir, r_hdir, r_vacc, r_hacc, r_last)};
                    n_ovalid = 1'b1;
                    n_count = '0; n_ovf = 1'b0; n_vacc = '0; n_hacc = '0;
                    n_vdir = '0; n_hdir = '0; n_near = '0; n_far = '0;
                    n_prox = gdc_pkg::PROX_NONE; n_last = gdc_pkg::MOT_NONE;
                end else if (push) begin
                    if (r_count < CW'(gdc_pkg::BufDepth)) begin
                        mem_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end else n_ovf = 1'b1;
                    if (s_axis_tlast) begin
                        if (r_ovf || r_count >= CW'(gdc_pkg::BufDepth)) begin
                            n_odata = {3'b100, r_last}; n_ovalid = 1'b1;
                            n_count = '0; n_ovf = 1'b0;
                        end else if (r_count + 1'b1 <= CW'(gdc_pkg::MinBatch)) begin
                            n_odata = {3'b000, r_last}; n_ovalid = 1'b1;
                            n_count = '0;
                        end else begin
                            n_ptr = '0; n_state = gdc_pkg::ST_SCAN_FWD;
                        end
                    end
                end
            end
            gdc_pkg::ST_SCAN_FWD: begin
                // The pushed write completes before this read is issued.
                if (r_rd_pend && rdv) begin
                    n_first = r_rdata;
                    n_ptr = r_count - 1'b1;
                    mem_raddr = n_ptr[IW-1:0];
                    n_rd_pend = 1'b1;
                    n_state = gdc_pkg::ST_SCAN_BWD;
                end else if (r_rd_pend && r_ptr == r_count) begin
                    n_odata = {3'b000, r_last}; n_ovalid = 1'b1;
                    n_count = '0; n_state = gdc_pkg::ST_OUT;
                end else begin
                    mem_raddr = r_ptr[IW-1:0];
                    n_ptr = r_ptr + 1'b1;
                    n_rd_pend = 1'b1;
                end
            end
            gdc_pkg::ST_SCAN_BWD: begin
                // A valid entry exists, so this scan always ends.
                if (r_rd_pend && rdv) begin
                    n_lastw = r_rdata;
                    n_dsel = '0; n_dbusy = 1'b0;
                    n_state = gdc_pkg::ST_DIV;
                end else if (r_rd_pend) begin
                    n_ptr = r_ptr - 1'b1;
                    mem_raddr = n_ptr[IW-1:0];
                    n_rd_pend = 1'b1;
                end
            end
            gdc_pkg::ST_DIV: begin
                if (!r_dbusy) begin
                    n_dneg = da < db;
                    ddiff = (da < db) ? db - da : da - db;
                    n_dq = {7'b0, ddiff} * 15'd100;
                    n_dden = {1'b0, da} + {1'b0, db};
                    n_drem = '0; n_dstep = '0; n_dbusy = 1'b1;
                end else begin
                    // One restoring step per cycle.
                    dshift = {r_drem, r_dq[14]};
                    dtrial = {1'b0, dshift} - {2'b00, r_dden};
                    if (!dtrial[10]) begin
                        n_drem = dtrial[8:0]; n_dq = {r_dq[13:0], 1'b1};
                    end else begin
                        n_drem = dshift[8:0]; n_dq = {r_dq[13:0], 1'b0};
                    end
                    n_dstep = r_dstep + 1'b1;
                    if (r_dstep == 4'd14) begin
                        dqmag = n_dq[7:0];
                        n_ratio[r_dsel] = r_dneg ? -signed'(dqmag) : signed'(dqmag);
                        n_dbusy = 1'b0;
                        n_dsel = r_dsel + 1'b1;
                        if (r_dsel == 2'd3) n_state = gdc_pkg::ST_UPDATE;
                    end
                end
            end
            gdc_pkg::ST_UPDATE: begin
                n_vacc = vacc_new; n_hacc = hacc_new;
                n_vdir = dir_f(vacc_new, r_swipe);
                n_hdir = dir_f(hacc_new, r_swipe);
                n_state = gdc_pkg::ST_RULES;
            end
            gdc_pkg::ST_RULES: begin
                n_odata = {3'b000, r_last};
                if (still) begin
                    if (r_vdir == 2'sd0 && r_hdir == 2'sd0) begin
                        if (both_zero) begin
                            if (r_near != 8'hFF) n_near = r_near + 1'b1;
                        end else if (r_far != 8'hFF) n_far = r_far + 1'b1;
                        if (n_near >= 8'(gdc_pkg::NearNeeded)
                                && n_far >= 8'(gdc_pkg::FarNeeded)) begin
                            if (both_zero) n_prox = gdc_pkg::PROX_NEAR;
                            else if (ud != 9'sd0 && lr != 9'sd0) n_prox = gdc_pkg::PROX_FAR;
                            n_odata = {3'b001,
                                decode_f(n_prox, r_vdir, r_hdir, r_vacc, r_hacc, r_last)};
                            n_last = gdc_pkg::t_motion'(n_odata[2:0]);
                        end
                    end else begin
                        if (both_zero && r_near != 8'hFF) n_near = r_near + 1'b1;
                        if (n_near >= 8'(gdc_pkg::NearNeeded)) begin
                            n_vdir = '0; n_hdir = '0; n_vacc = '0; n_hacc = '0;
                        end
                    end
                end
                n_ovalid = 1'b1; n_count = '0;
                n_state = gdc_pkg::ST_OUT;
            end
            gdc_pkg::ST_OUT: begin
                if (!r_ovalid || m_axis_tready) n_state = gdc_pkg::ST_IDLE;
            end
            default: n_state = gdc_pkg::ST_IDLE;
        endcase
    end

    // Assertions.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gdc_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(gdc_pkg::BufDepth))
        else $error("sample count beyond depth");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (r_count == '0 && r_prox == gdc_pkg::PROX_NONE && r_ovalid))
        else $error("finish did not clear state");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> $countones(r_odata[5:3]) <= 1)
        else $error("conflicting result flags");

endmodule
